@@ rtl/cae_pkg.sv @@
// ----------------------------------------------------------------------------
// cae_pkg: arc endpoint range query package
// Shared sizes, item codes and the entry / control types of the cell chain.
// ----------------------------------------------------------------------------
package cae_pkg;

    // sizes
    localparam int MAX_ENTRIES = 192;
    localparam int COORD_BITS  = 20;
    localparam int RING_BITS   = 20;
    localparam int VAL_BITS    = COORD_BITS + 2;
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
    localparam int GROUP       = 8;
    localparam int NUM_GROUPS  = (MAX_ENTRIES + GROUP - 1) / GROUP;

    // item codes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // one stored arc copy
    typedef struct packed {
        logic                valid;
        logic [VAL_BITS-1:0] start_pt;
        logic [VAL_BITS-1:0] end_pt;
    } cae_entry_t;

    // control from the sequencer to the chain
    typedef struct packed {
        logic                shift_en;
        cae_entry_t          ins;
        logic [VAL_BITS-1:0] qx;
        logic [VAL_BITS-1:0] qy;
    } cae_ctrl_t;

endpackage

@@ rtl/cae_if.sv @@
// ----------------------------------------------------------------------------
// cae_in_if / cae_out_if: item channels
// Valid/ready channels for query and load items and for query results.
// ----------------------------------------------------------------------------
interface cae_in_if import cae_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] start_coord;
    logic [COORD_BITS-1:0] stop_coord;

    modport source (output valid, output mode, output start_coord, output stop_coord,
                    input ready);
    modport sink   (input valid, input mode, input start_coord, input stop_coord,
                    output ready);
endinterface

interface cae_out_if import cae_pkg::*; ();
    logic valid;
    logic ready;
    logic free_of_endpoints;
    logic overflow_seen;

    modport source (output valid, output free_of_endpoints, output overflow_seen,
                    input ready);
    modport sink   (input valid, input free_of_endpoints, input overflow_seen,
                    output ready);
endinterface

@@ rtl/cae_cell.sv @@
// ----------------------------------------------------------------------------
// cae_cell: one storage cell of the endpoint chain
// Holds one arc copy, shifts it to the next cell on insert, and compares it
// against the broadcast query bounds.
// ----------------------------------------------------------------------------
module cae_cell import cae_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  cae_entry_t          prev_ent,
    input  logic [VAL_BITS-1:0] qx,
    input  logic [VAL_BITS-1:0] qy,
    output cae_entry_t          ent,
    output logic                hit
);

    logic                valid_reg;
    logic [VAL_BITS-1:0] start_reg;
    logic [VAL_BITS-1:0] end_reg;
    logic                hit_reg;
    logic                hit_next;

    // start point in (qx, qy], end point in [qx, qy)
    always_comb
    begin
        hit_next = valid_reg &&
                   (((start_reg > qx) && (start_reg <= qy)) ||
                    ((end_reg >= qx) && (end_reg < qy)));
    end

    // valid and hit flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
            if (shift_en)
            begin
                valid_reg <= prev_ent.valid;
            end
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            start_reg <= prev_ent.start_pt;
            end_reg   <= prev_ent.end_pt;
        end
    end

    assign ent.valid    = valid_reg;
    assign ent.start_pt = start_reg;
    assign ent.end_pt   = end_reg;
    assign hit          = hit_reg;

endmodule

@@ rtl/cae_chain.sv @@
// ----------------------------------------------------------------------------
// cae_chain: row of endpoint cells with a registered hit tree
// New copies enter at cell zero and push older ones along; the per-cell hit
// flags are reduced in two registered levels.
// ----------------------------------------------------------------------------
module cae_chain import cae_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cae_ctrl_t ctrl,
    output logic      any_hit
);

    cae_entry_t                    cell_ent [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]        hit_vec;
    logic [NUM_GROUPS*GROUP-1:0]   hit_pad;
    logic [NUM_GROUPS-1:0]         group_reg;
    logic                          any_hit_reg;

    // cell row
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        cae_entry_t prev_ent;
        if (i == 0)
        begin : g_head
            assign prev_ent = ctrl.ins;
        end
        else
        begin : g_body
            assign prev_ent = cell_ent[i-1];
        end

        cae_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (ctrl.shift_en),
            .prev_ent (prev_ent),
            .qx       (ctrl.qx),
            .qy       (ctrl.qy),
            .ent      (cell_ent[i]),
            .hit      (hit_vec[i])
        );
    end

    // pad hits to whole groups
    always_comb
    begin
        hit_pad                  = '0;
        hit_pad[MAX_ENTRIES-1:0] = hit_vec;
    end

    // two-level or tree
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg   <= '0;
            any_hit_reg <= 1'b0;
        end
        else
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                group_reg[g] <= |hit_pad[g*GROUP +: GROUP];
            end
            any_hit_reg <= |group_reg;
        end
    end

    assign any_hit = any_hit_reg;

endmodule

@@ rtl/circular_arc_endpoint_range_query.sv @@
// ----------------------------------------------------------------------------
// circular_arc_endpoint_range_query: arc endpoint range query on a ring
// Loads unrolled arc copies into a cell chain and answers whether a query arc
// holds no stored start or end point.
// ----------------------------------------------------------------------------
// Load item: one copy enters the chain per cycle, 3 copies in all (2 if it wraps);
//   a load that does not fit is dropped and sets the sticky overflow flag.
// Query item: query register, compare, group or, final or, output register;
//   the output register waits while an earlier result is not yet taken.
// One item at a time; a pending result does not block loads.
// Reset: chain empty, count and overflow flag clear, ring_size 1048575.
module circular_arc_endpoint_range_query import cae_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cae_in_if.sink               in_ch,
    cae_out_if.source            out_ch,
    input  logic                 cfg_wr_en,
    input  logic [RING_BITS-1:0] cfg_wr_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_GRP  = 3'd3;
    localparam logic [2:0] ST_ANY  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [RING_BITS-1:0] RING_RESET = RING_BITS'(1048575);

    logic [2:0]           state_reg,     state_next;
    logic [RING_BITS-1:0] ring_reg;
    logic [CNT_BITS-1:0]  count_reg,     count_next;
    logic                 ovf_reg,       ovf_next;
    logic [1:0]           rem_reg,       rem_next;
    logic [VAL_BITS-1:0]  cur_s_reg,     cur_s_next;
    logic [VAL_BITS-1:0]  cur_e_reg,     cur_e_next;
    logic [VAL_BITS-1:0]  qx_reg,        qx_next;
    logic [VAL_BITS-1:0]  qy_reg,        qy_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free_reg,  out_free_next;
    logic                 out_ovf_reg,   out_ovf_next;

    logic                 accept;
    logic                 wrap;
    logic [1:0]           copies;
    logic [CNT_BITS:0]    count_sum;
    logic                 fits;
    logic [VAL_BITS-1:0]  x_ext;
    logic [VAL_BITS-1:0]  y_ext;
    logic [VAL_BITS-1:0]  n_ext;
    logic [VAL_BITS-1:0]  y_adj;
    logic                 any_hit;
    cae_ctrl_t            ctrl;

    // input decode
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign x_ext       = VAL_BITS'(in_ch.start_coord);
    assign y_ext       = VAL_BITS'(in_ch.stop_coord);
    assign n_ext       = VAL_BITS'(ring_reg);
    assign wrap        = in_ch.start_coord > in_ch.stop_coord;
    assign copies      = wrap ? 2'd2 : 2'd3;
    assign count_sum   = (CNT_BITS+1)'(count_reg) + (CNT_BITS+1)'(copies);
    assign fits        = count_sum <= (CNT_BITS+1)'(MAX_ENTRIES);
    assign y_adj       = wrap ? (y_ext + n_ext) : y_ext;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        rem_next       = rem_reg;
        cur_s_next     = cur_s_reg;
        cur_e_next     = cur_e_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        out_valid_next = out_valid_reg;
        out_free_next  = out_free_reg;
        out_ovf_next   = out_ovf_reg;

        ctrl.shift_en     = 1'b0;
        ctrl.ins.valid    = 1'b1;
        ctrl.ins.start_pt = cur_s_reg;
        ctrl.ins.end_pt   = cur_e_reg;
        ctrl.qx           = qx_reg;
        ctrl.qy           = qy_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.mode == MODE_LOAD)
                    begin
                        if (fits)
                        begin
                            // first copy goes in right away
                            ctrl.shift_en     = 1'b1;
                            ctrl.ins.start_pt = x_ext;
                            ctrl.ins.end_pt   = y_adj;
                            cur_s_next        = x_ext + n_ext;
                            cur_e_next        = y_adj + n_ext;
                            rem_next          = copies - 2'd1;
                            count_next        = CNT_BITS'(count_sum);
                            state_next        = ST_LOAD;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // shift query onto the middle copy of the ring
                        qx_next    = wrap ? x_ext : (x_ext + n_ext);
                        qy_next    = y_ext + n_ext;
                        state_next = ST_CMP;
                    end
                end
            end
            ST_LOAD:
            begin
                ctrl.shift_en = 1'b1;
                cur_s_next    = cur_s_reg + n_ext;
                cur_e_next    = cur_e_reg + n_ext;
                rem_next      = rem_reg - 2'd1;
                if (rem_reg == 2'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CMP:
            begin
                state_next = ST_GRP;
            end
            ST_GRP:
            begin
                state_next = ST_ANY;
            end
            ST_ANY:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_free_next  = !any_hit;
                    out_ovf_next   = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ring_reg      <= RING_RESET;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                ring_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_s_reg    <= cur_s_next;
        cur_e_reg    <= cur_e_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        out_free_reg <= out_free_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // endpoint cell chain
    cae_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .any_hit (any_hit)
    );

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.free_of_endpoints = out_free_reg;
    assign out_ch.overflow_seen     = out_ovf_reg;

    // fill count never passes capacity
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_ENTRIES))
        else $error("entry count above capacity");

    // overflow flag is sticky
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    // a query item is followed by a valid result on the output
    a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_ch.mode == MODE_QUERY)) |-> ##5 out_ch.valid)
        else $error("query result missing");

    // load sequencing always has copies left to insert
    a_load_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (rem_reg != 2'd0))
        else $error("load state with no copies left");

endmodule
